// ===== rtl/core/sine_squared_series_evaluator_defines.svh =====
// Assertion macros shared by the sine-squared series evaluator RTL
`ifndef SINE_SQUARED_SERIES_EVALUATOR_DEFINES_SVH
`define SINE_SQUARED_SERIES_EVALUATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during reset
`define SSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sse: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sse: assertion failed");

`else

`define SSE_ASSERT_IMP(lbl, ante, cons)
`define SSE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/sse_pkg.sv =====
// Shared constants and types for the sine-squared series evaluator
package sse_pkg;

  // default configuration
  localparam int MAX_TERMS_DEF = 12;
  localparam int FRAC_BITS_DEF = 30;

  // fixed port widths
  localparam int ANGLE_W = 32;
  localparam int SINE_W  = 31;
  localparam int TERMS_W = 4;

  // 1.0 in Q0.30
  localparam logic [SINE_W-1:0] ONE_Q30 = 31'h4000_0000;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } sse_sts_t;

endpackage

// ===== rtl/core/sse_ser_mul.sv =====
// Serial-parallel fixed-point multiplier, one multiplier bit per cycle, rounded half up
module sse_ser_mul import sse_pkg::*; #(
  parameter int W = FRAC_BITS_DEF + 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] p,
  output sse_sts_t     sts
);

  localparam int CW = $clog2(W + 1);

  typedef enum logic [1:0] {
    M_IDLE,
    M_RUN,
    M_RND
  } mst_t;

  mst_t          st_r;
  logic [W-1:0]  a_r;
  logic [W-1:0]  acc_r;
  logic [W-1:0]  mq_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  p_r;
  logic          done_r;

  logic [W:0]    add_v;
  logic [W-1:0]  rnd_v;

  // partial product add for the current multiplier bit
  assign add_v = {1'b0, acc_r} + (mq_r[0] ? {1'b0, a_r} : {(W+1){1'b0}});

  // product >> F plus the bit just below the binary point
  assign rnd_v = W'({acc_r, mq_r[W-1]} + (W+1)'(mq_r[W-2]));

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        M_IDLE: begin
          if (start) begin
            a_r   <= a;
            mq_r  <= b;
            acc_r <= '0;
            cnt_r <= '0;
            st_r  <= M_RUN;
          end
        end
        M_RUN: begin
          // shift the product down one place, multiplier bits fall out the bottom
          acc_r <= add_v[W:1];
          mq_r  <= {add_v[0], mq_r[W-1:1]};
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(W - 1)) begin
            st_r <= M_RND;
          end
        end
        M_RND: begin
          p_r    <= rnd_v;
          done_r <= 1'b1;
          st_r   <= M_IDLE;
        end
        default: begin
          st_r <= M_IDLE;
        end
      endcase
    end
  end

  assign p        = p_r;
  assign sts.busy = (st_r != M_IDLE);
  assign sts.done = done_r;

endmodule

// ===== rtl/core/sse_ser_div.sv =====
// Restoring divider, one quotient bit per cycle, narrow divisor
module sse_ser_div import sse_pkg::*; #(
  parameter int NB = FRAC_BITS_DEF + 3,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NB-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NB-1:0] quot,
  output sse_sts_t      sts
);

  localparam int CW = $clog2(NB + 1);

  typedef enum logic {
    D_IDLE,
    D_RUN
  } dst_t;

  dst_t          st_r;
  logic [NB-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic          done_r;

  logic [DW:0]   t_v;
  logic          ge_v;
  logic [DW:0]   diff_v;

  // trial subtract of the divisor from the shifted remainder
  assign t_v    = {rem_r, q_r[NB-1]};
  assign ge_v   = (t_v >= {1'b0, d_r});
  assign diff_v = t_v - {1'b0, d_r};

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        D_IDLE: begin
          if (start) begin
            q_r   <= dividend;
            d_r   <= divisor;
            rem_r <= '0;
            cnt_r <= '0;
            st_r  <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= ge_v ? diff_v[DW-1:0] : t_v[DW-1:0];
          q_r   <= {q_r[NB-2:0], ge_v};
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(NB - 1)) begin
            done_r <= 1'b1;
            st_r   <= D_IDLE;
          end
        end
        default: begin
          st_r <= D_IDLE;
        end
      endcase
    end
  end

  assign quot     = q_r;
  assign sts.busy = (st_r != D_IDLE);
  assign sts.done = done_r;

endmodule

// ===== rtl/core/sine_squared_series_evaluator.sv =====
// Sine-squared Maclaurin series evaluator: top level, sequencer and accumulator
//
// Takes a signed Q1.30 angle (saturated to -1..1) and returns sin^2 of it as unsigned
// Q0.30 together with the number of series terms summed. The series runs on
// FRAC_BITS fraction bits: one bit-serial multiplier forms x^2, each further power of
// x and each term, while a bit-serial divider produces the next coefficient alongside
// the power multiply. Summation stops at the first term that rounds to zero or after
// MAX_TERMS terms. One item is worked at a time, and the sequencer is ready for the next
// angle in the cycle after a result is registered. A finished result sits in an output
// register, and the next angle may be taken while it waits; a result that is still
// waiting holds the following one in the sequencer until it has been transferred.
`include "sine_squared_series_evaluator_defines.svh"

module sine_squared_series_evaluator import sse_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ANGLE_W-1:0] in_angle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [SINE_W-1:0]         out_sine_squared,
  output logic [TERMS_W-1:0]        out_terms_used
);

  localparam int W   = FRAC_BITS + 1;
  localparam int SW  = FRAC_BITS + 3;
  localparam int NB  = FRAC_BITS + 3;
  localparam int KW  = $clog2(MAX_TERMS + 2);
  localparam int DW  = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS - 1) + 1);
  localparam int CVW = 34;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SQR,
    ST_NEXT,
    ST_WAIT,
    ST_TGO,
    ST_TERM,
    ST_FIN
  } state_t;

  state_t                state_r;
  state_t                state_nxt;
  logic [ANGLE_W-1:0]    ang_r;
  logic [W-1:0]          x2_r;
  logic [W-1:0]          pw_r;
  logic [W-1:0]          coef_r;
  logic signed [SW-1:0]  sum_r;
  logic [KW-1:0]         k_r;
  logic                  out_valid_r;
  logic [SINE_W-1:0]     out_sine_r;
  logic [TERMS_W-1:0]    out_terms_r;

  logic [ANGLE_W-1:0]    mag_v;
  logic [SINE_W-1:0]     mag31_v;
  logic [W-1:0]          ax_v;
  logic                  k_le_v;
  logic [KW:0]           k2_v;
  logic [DW-1:0]         d_v;
  logic [NB-1:0]         dvd_v;
  logic signed [SW-1:0]  term_v;
  logic [CVW-1:0]        conv_v;
  logic [SINE_W-1:0]     res_v;
  logic                  load_out;
  logic                  both_idle;

  logic                  mul_start;
  logic [W-1:0]          mul_a;
  logic [W-1:0]          mul_b;
  logic [W-1:0]          mul_p;
  sse_sts_t              mul_sts;
  logic                  div_start;
  logic [NB-1:0]         div_q;
  sse_sts_t              div_sts;

  // angle magnitude, saturated to 1.0
  assign mag_v   = ang_r[ANGLE_W-1] ? (~ang_r + ANGLE_W'(1)) : ang_r;
  assign mag31_v = (mag_v > {1'b0, ONE_Q30}) ? ONE_Q30 : mag_v[SINE_W-1:0];

  // Q0.30 magnitude to the working format
  generate
    if (FRAC_BITS >= 30) begin : g_ax_up
      assign ax_v = W'(mag31_v) << (FRAC_BITS - 30);
    end else begin : g_ax_dn
      logic [SINE_W-1:0] rnd_v;
      assign rnd_v = mag31_v + (SINE_W'(1) << (29 - FRAC_BITS));
      assign ax_v  = W'(rnd_v >> (30 - FRAC_BITS));
    end
  endgenerate

  // coefficient divisor d = 2k(2k-1) and rounded dividend 4c + d/2
  assign k_le_v = (k_r <= KW'(MAX_TERMS));
  assign k2_v   = {k_r, 1'b0};
  assign d_v    = DW'(k2_v) * (DW'(k2_v) - DW'(1));
  assign dvd_v  = NB'({coef_r, 2'b00}) + NB'(d_v >> 1);

  // current term, sign-extended to the accumulator
  assign term_v = $signed({2'b00, mul_p});

  // sum back to Q0.30
  generate
    if (FRAC_BITS > 30) begin : g_out_dn
      logic [SW:0] rsum_v;
      assign rsum_v = (SW+1)'(sum_r) + ((SW+1)'(1) << (FRAC_BITS - 31));
      assign conv_v = CVW'(rsum_v >> (FRAC_BITS - 30));
    end else begin : g_out_up
      assign conv_v = CVW'(sum_r) << (30 - FRAC_BITS);
    end
  endgenerate

  // clamp to 0..1.0
  always_comb begin
    if (sum_r[SW-1]) begin
      res_v = '0;
    end else if (conv_v > CVW'(ONE_Q30)) begin
      res_v = ONE_Q30;
    end else begin
      res_v = conv_v[SINE_W-1:0];
    end
  end

  assign both_idle = !mul_sts.busy && !div_sts.busy;
  assign load_out  = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // unit starts and multiplier operand selection
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = pw_r;
    mul_b     = x2_r;
    unique case (state_r)
      ST_CONV: begin
        mul_start = 1'b1;
        mul_a     = ax_v;
        mul_b     = ax_v;
      end
      ST_NEXT: begin
        mul_start = k_le_v;
        div_start = k_le_v;
      end
      ST_TGO: begin
        mul_start = 1'b1;
        mul_a     = coef_r;
        mul_b     = pw_r;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_CONV;
      ST_CONV: state_nxt = ST_SQR;
      ST_SQR:  if (mul_sts.done) state_nxt = ST_NEXT;
      ST_NEXT: state_nxt = k_le_v ? ST_WAIT : ST_FIN;
      ST_WAIT: if (both_idle) state_nxt = ST_TGO;
      ST_TGO:  state_nxt = ST_TERM;
      ST_TERM: begin
        if (mul_sts.done) begin
          state_nxt = (mul_p == '0) ? ST_FIN : ST_NEXT;
        end
      end
      ST_FIN:  if (load_out) state_nxt = ST_IDLE;
    endcase
  end

  // state, accumulator and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == ST_IDLE && in_valid) begin
        ang_r <= in_angle;
      end

      // first term is x^2 itself
      if (state_r == ST_SQR && mul_sts.done) begin
        x2_r   <= mul_p;
        pw_r   <= mul_p;
        sum_r  <= term_v;
        coef_r <= {1'b1, {FRAC_BITS{1'b0}}};
        k_r    <= KW'(2);
      end

      // new coefficient and power
      if (state_r == ST_WAIT && both_idle) begin
        coef_r <= W'(div_q);
        pw_r   <= mul_p;
      end

      // add or subtract a non-zero term
      if (state_r == ST_TERM && mul_sts.done && mul_p != '0) begin
        sum_r <= k_r[0] ? (sum_r + term_v) : (sum_r - term_v);
        k_r   <= k_r + KW'(1);
      end

      if (load_out) begin
        out_sine_r  <= res_v;
        out_terms_r <= TERMS_W'(k_r - KW'(1));
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // serial arithmetic units
  sse_ser_mul #(
    .W(W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .sts   (mul_sts)
  );

  sse_ser_div #(
    .NB(NB),
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_v),
    .divisor  (d_v),
    .quot     (div_q),
    .sts      (div_sts)
  );

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_sine_squared = out_sine_r;
  assign out_terms_used   = out_terms_r;

  // term index stays within the series while it is being summed
  `SSE_ASSERT_IMP(a_k_range,
                  (state_r == ST_NEXT || state_r == ST_WAIT || state_r == ST_TERM),
                  (k_r >= KW'(2) && k_r <= KW'(MAX_TERMS + 1)))
  // multiplier results only arrive when the sequencer waits for one
  `SSE_ASSERT_IMP(a_mul_done, mul_sts.done,
                  (state_r == ST_SQR || state_r == ST_WAIT || state_r == ST_TERM))
  // divider results only arrive while waiting for the coefficient
  `SSE_ASSERT_IMP(a_div_done, div_sts.done, (state_r == ST_WAIT))
  // a new angle finds both units free
  `SSE_ASSERT_NXT(a_units_free, (in_valid && in_ready),
                  (!mul_sts.busy && !div_sts.busy))

endmodule
